>>> hdl/i32au_pkg.sv
// Shared types and constants of the 32-bit integer arithmetic unit.
// No dependencies; every other file of the unit imports this package.
`default_nettype none

package i32au_pkg;

   localparam int WORD_BITS = 32;
   localparam int FUNC_BITS = 3;

   // Operation codes of a request
   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_ADD = 3'd0,
      FUNC_SUB = 3'd1,
      FUNC_MUL = 3'd2,
      FUNC_DIV = 3'd3,
      FUNC_MOD = 3'd4
   } func_type;

   typedef logic [WORD_BITS-1:0] word_type;

   // Payload handed from cell to cell.
   //   acc : sum/difference, running product or quotient bits
   //   x   : multiplicand (shifted left) or dividend bits still to shift in
   //   y   : multiplier (shifted right) or divisor magnitude
   //   rem : partial remainder, one bit wider than a word
   typedef struct packed {
      func_type             func;
      logic                 neg;
      word_type             acc;
      word_type             x;
      word_type             y;
      logic [WORD_BITS:0]   rem;
   } stage_type;

   // Two's complement negate, wrapping
   function automatic word_type negate(input word_type v);
      negate = ~v + word_type'(1);
   endfunction

   // Magnitude of a signed word; the minimum integer maps to itself
   function automatic word_type magnitude(input word_type v);
      magnitude = v[WORD_BITS-1] ? negate(v) : v;
   endfunction

endpackage

`default_nettype wire

>>> hdl/i32au_if.sv
// Valid/ready channel interfaces for requests and results of the unit.
// Depends on i32au_pkg for the word width.
`default_nettype none

interface i32au_req_if import i32au_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [FUNC_BITS-1:0] func;
   logic [WORD_BITS-1:0] operand_a;
   logic [WORD_BITS-1:0] operand_b;

   modport source (output valid, func, operand_a, operand_b, input ready);
   modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface i32au_rsp_if import i32au_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);
endinterface

`default_nettype wire

>>> hdl/i32au_cell.sv
// One cell of the arithmetic chain: one shift-and-add multiply step or one
// restoring divide step (other requests pass through unchanged), then a register. Depends on i32au_pkg.
`default_nettype none

module i32au_cell import i32au_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire logic      prev_valid,
   input  wire stage_type prev_data,
   output logic           cell_valid,
   output stage_type      cell_data
);

   logic                valid_ff;
   logic                valid_in;
   stage_type           data_ff;
   stage_type           data_in;
   logic [WORD_BITS:0]  shifted;
   logic [WORD_BITS:0]  divisor;

   // One step of the selected operation
   always_comb begin
      data_in = prev_data;
      shifted = {prev_data.rem[WORD_BITS-1:0], prev_data.x[WORD_BITS-1]};
      divisor = {1'b0, prev_data.y};
      case (prev_data.func)
         FUNC_MUL: begin
            if (prev_data.y[0]) begin
               data_in.acc = prev_data.acc + prev_data.x;
            end
            data_in.x = {prev_data.x[WORD_BITS-2:0], 1'b0};
            data_in.y = {1'b0, prev_data.y[WORD_BITS-1:1]};
         end
         FUNC_DIV, FUNC_MOD: begin
            data_in.x = {prev_data.x[WORD_BITS-2:0], 1'b0};
            if (shifted >= divisor) begin
               data_in.rem = shifted - divisor;
               data_in.acc = {prev_data.acc[WORD_BITS-2:0], 1'b1};
            end else begin
               data_in.rem = shifted;
               data_in.acc = {prev_data.acc[WORD_BITS-2:0], 1'b0};
            end
         end
         default: begin
            data_in = prev_data;
         end
      endcase
   end

   assign valid_in = prev_valid;

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign cell_valid = valid_ff;
   assign cell_data  = data_ff;

endmodule

`default_nettype wire

>>> hdl/i32au_chain.sv
// Row of WORD_BITS arithmetic cells, each passing its request to the next.
// Depends on i32au_pkg and i32au_cell.
`default_nettype none

module i32au_chain import i32au_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire logic      head_valid,
   input  wire stage_type head_data,
   output logic           tail_valid,
   output stage_type      tail_data
);

   logic      link_valid [0:WORD_BITS];
   stage_type link_data  [0:WORD_BITS];

   assign link_valid[0] = head_valid;
   assign link_data[0]  = head_data;

   // One cell per quotient / multiplier bit
   for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
      i32au_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .prev_valid (link_valid[i]),
         .prev_data  (link_data[i]),
         .cell_valid (link_valid[i+1]),
         .cell_data  (link_data[i+1])
      );
   end

   assign tail_valid = link_valid[WORD_BITS];
   assign tail_data  = link_data[WORD_BITS];

endmodule

`default_nettype wire

>>> hdl/int32_arith_unit.sv
// Top level of the 32-bit integer arithmetic unit: operand setup, cell
// chain, sign fix and result register. Depends on i32au_pkg, i32au_if,
// i32au_chain.
//
//  channel  | dir | handshake                | payload
//  ---------+-----+--------------------------+-------------------------------
//  req_ch   | in  | req_ch.valid/req_ch.ready | func, operand_a, operand_b
//  rsp_ch   | out | rsp_ch.valid/rsp_ch.ready | result
//
// Every request runs through 34 register stages: operand setup, 32 cells
// (one multiply or divide step each), and the result register. A new
// request is taken every cycle when not stalled. The whole pipeline moves
// together: it holds while a result sits in the output register and
// rsp_ch.ready is low, and req_ch.ready drops then.
// Synchronous reset clears all valid bits; payload is not reset.
`default_nettype none

module int32_arith_unit import i32au_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   i32au_req_if.sink   req_ch,
   i32au_rsp_if.source rsp_ch
);

   logic      pipe_en;
   logic      prep_valid_ff;
   stage_type prep_data_ff;
   stage_type prep_data_in;
   logic      tail_valid;
   stage_type tail_data;
   logic      rsp_valid_ff;
   word_type  rsp_result_ff;
   word_type  rsp_result_in;
   func_type  req_func;
   word_type  op_a;
   word_type  op_b;

   // Pipeline moves unless the output register holds an untaken result
   assign pipe_en      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = pipe_en;

   assign req_func = func_type'(req_ch.func);
   assign op_a     = req_ch.operand_a;
   assign op_b     = req_ch.operand_b;

   // Operand setup
   always_comb begin
      prep_data_in.func = req_func;
      prep_data_in.neg  = 1'b0;
      prep_data_in.acc  = '0;
      prep_data_in.x    = op_a;
      prep_data_in.y    = op_b;
      prep_data_in.rem  = '0;
      case (req_func)
         FUNC_ADD: begin
            prep_data_in.acc = op_a + op_b;
         end
         FUNC_SUB: begin
            prep_data_in.acc = op_a - op_b;
         end
         FUNC_MUL: begin
            prep_data_in.acc = '0;
         end
         FUNC_DIV: begin
            prep_data_in.x   = magnitude(op_a);
            prep_data_in.y   = magnitude(op_b);
            prep_data_in.neg = op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
         end
         FUNC_MOD: begin
            prep_data_in.x   = magnitude(op_a);
            prep_data_in.y   = magnitude(op_b);
            prep_data_in.neg = op_a[WORD_BITS-1];
         end
         default: begin
            prep_data_in.acc = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         prep_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         prep_data_ff <= prep_data_in;
      end
   end

   i32au_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .advance    (pipe_en),
      .head_valid (prep_valid_ff),
      .head_data  (prep_data_ff),
      .tail_valid (tail_valid),
      .tail_data  (tail_data)
   );

   // Sign fix and result select
   always_comb begin
      case (tail_data.func)
         FUNC_ADD, FUNC_SUB, FUNC_MUL: begin
            rsp_result_in = tail_data.acc;
         end
         FUNC_DIV: begin
            rsp_result_in = tail_data.neg ? negate(tail_data.acc) : tail_data.acc;
         end
         FUNC_MOD: begin
            rsp_result_in = tail_data.neg ? negate(tail_data.rem[WORD_BITS-1:0])
                                          : tail_data.rem[WORD_BITS-1:0];
         end
         default: begin
            rsp_result_in = '0;
         end
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= tail_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.result = rsp_result_ff;

   // A waiting result must block new requests
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken while result stalled");

   // Reset empties the output register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   // A stalled pipeline keeps the request at the chain end in place
   a_tail_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(tail_valid) && $stable(tail_data))
      else $error("chain moved during stall");

endmodule

`default_nettype wire

>>> test/int32_arith_unit_test.sv
// Self-checking testbench of int32_arith_unit: directed corner requests, then random ones,
// with random idle on both channels. Depends on i32au_pkg, i32au_if and the unit itself.
`timescale 1ns / 1ps

module int32_arith_unit_test import i32au_pkg::*;;

   // Codes that the unit accepts but does not define
   localparam logic [FUNC_BITS-1:0] FUNC_SPARE_5 = 3'd5;
   localparam logic [FUNC_BITS-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [FUNC_BITS-1:0] FUNC_SPARE_7 = 3'd7;

   localparam word_type MIN_INT = 32'h8000_0000;
   localparam word_type MAX_INT = 32'h7FFF_FFFF;
   localparam word_type MINUS_1 = 32'hFFFF_FFFF;

   localparam int RANDOM_REQUESTS = 1426;
   localparam int DRAIN_CYCLES    = 40;

   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      word_type             operand_a;
      word_type             operand_b;
   } arith_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   i32au_req_if req_ch ();
   i32au_rsp_if rsp_ch ();

   int32_arith_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   arith_request_type pending_requests[$];
   word_type          expected_results[$];
   int                fail_count = 0;

   int   send_gap   = 0;
   logic send_calm  = 1'b0;
   int   recv_stall = 0;
   logic recv_calm  = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Expected result of one request: wrapping add/sub/multiply, restoring divide on magnitudes
   function automatic word_type compute_result(input logic [FUNC_BITS-1:0] func,
                                               input word_type a, input word_type b);
      word_type           mag_a;
      word_type           mag_b;
      word_type           dividend;
      word_type           quotient;
      logic [WORD_BITS:0] partial;
      int                 i;
      mag_a    = a[WORD_BITS-1] ? -a : a;
      mag_b    = b[WORD_BITS-1] ? -b : b;
      dividend = mag_a;
      quotient = '0;
      partial  = '0;
      // one quotient bit per step; divisor zero lets every step succeed
      for (i = 0; i < WORD_BITS; i++) begin
         partial  = {partial[WORD_BITS-1:0], dividend[WORD_BITS-1]};
         dividend = dividend << 1;
         if (partial >= {1'b0, mag_b}) begin
            partial  = partial - {1'b0, mag_b};
            quotient = {quotient[WORD_BITS-2:0], 1'b1};
         end else begin
            quotient = {quotient[WORD_BITS-2:0], 1'b0};
         end
      end
      case (func)
         FUNC_ADD: compute_result = a + b;
         FUNC_SUB: compute_result = a - b;
         FUNC_MUL: compute_result = a * b;
         FUNC_DIV: begin
            compute_result = (a[WORD_BITS-1] ^ b[WORD_BITS-1]) ? -quotient : quotient;
         end
         FUNC_MOD: begin
            compute_result = a[WORD_BITS-1] ? -partial[WORD_BITS-1:0]
                                            : partial[WORD_BITS-1:0];
         end
         default: compute_result = '0;
      endcase
   endfunction

   // Operand mix: full range, small values, extremes, scaled values, large magnitudes
   function automatic word_type draw_operand();
      word_type v;
      case ($urandom_range(0, 5))
         1: v = word_type'($urandom_range(0, 40)) - 32'd20;
         2: begin
            case ($urandom_range(0, 4))
               0:       v = MIN_INT;
               1:       v = MAX_INT;
               2:       v = '0;
               3:       v = MINUS_1;
               default: v = 32'd1;
            endcase
         end
         3: begin
            v = $urandom >> $urandom_range(0, WORD_BITS - 1);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
         4: begin
            // magnitude of at least 2^30 exercises the full-width compare
            v = 32'h4000_0000 | ($urandom & 32'h3FFF_FFFF);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic logic [FUNC_BITS-1:0] draw_func();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick < 2)       return FUNC_ADD;
      else if (pick < 4)  return FUNC_SUB;
      else if (pick < 7)  return FUNC_MUL;
      else if (pick < 11) return FUNC_DIV;
      else if (pick < 15) return FUNC_MOD;
      else                return FUNC_SPARE_5 + FUNC_BITS'($urandom_range(0, 2));
   endfunction

   task automatic queue_request(input logic [FUNC_BITS-1:0] func,
                                input word_type a, input word_type b);
      arith_request_type r;
      r.func      = func;
      r.operand_a = a;
      r.operand_b = b;
      pending_requests.push_back(r);
   endtask

   // Stimulus and end of run
   initial begin
      int n;
      req_ch.valid     = 1'b0;
      req_ch.func      = '0;
      req_ch.operand_a = '0;
      req_ch.operand_b = '0;
      rsp_ch.ready     = 1'b0;

      // wrap-around of add, subtract and multiply
      queue_request(FUNC_ADD, MAX_INT, 32'd1);
      queue_request(FUNC_ADD, MIN_INT, MINUS_1);
      queue_request(FUNC_SUB, MIN_INT, 32'd1);
      queue_request(FUNC_SUB, MAX_INT, MINUS_1);
      queue_request(FUNC_MUL, MAX_INT, MAX_INT);
      queue_request(FUNC_MUL, MIN_INT, MINUS_1);
      queue_request(FUNC_MUL, MINUS_1, MINUS_1);
      // minimum integer over minus one
      queue_request(FUNC_DIV, MIN_INT, MINUS_1);
      queue_request(FUNC_MOD, MIN_INT, MINUS_1);
      // divide by zero, both dividend signs
      queue_request(FUNC_DIV, 32'd12345, '0);
      queue_request(FUNC_DIV, -32'sd12345, '0);
      queue_request(FUNC_MOD, -32'sd12345, '0);
      queue_request(FUNC_MOD, MIN_INT, '0);
      queue_request(FUNC_DIV, '0, '0);
      // divisors of magnitude near or above 2^30
      queue_request(FUNC_DIV, MAX_INT, 32'h4000_0001);
      queue_request(FUNC_DIV, MAX_INT, MIN_INT);
      queue_request(FUNC_MOD, MIN_INT, MIN_INT);
      queue_request(FUNC_DIV, 32'h7FFF_FFFE, 32'hC000_0001);
      // truncation toward zero and remainder sign
      queue_request(FUNC_DIV, -32'sd7, 32'd2);
      queue_request(FUNC_MOD, -32'sd7, 32'd2);
      queue_request(FUNC_MOD, 32'd7, -32'sd2);
      // undefined codes give zero
      queue_request(FUNC_SPARE_5, MINUS_1, MINUS_1);
      queue_request(FUNC_SPARE_6, MINUS_1, MINUS_1);
      queue_request(FUNC_SPARE_7, MINUS_1, MINUS_1);

      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         queue_request(draw_func(), draw_operand(), draw_operand());
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_ch.valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("int32_arith_unit_test passed");
      end else begin
         $display("int32_arith_unit_test failed");
      end
      $finish;
   end

   // Request driver: random gap per request, back to back when the gap is zero
   always @(posedge clock) begin : drive_requests
      arith_request_type next_req;
      logic              holding;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         holding = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(compute_result(req_ch.func, req_ch.operand_a,
                                                      req_ch.operand_b));
            holding = 1'b0;
            if ($urandom_range(0, 63) == 0) send_calm = ~send_calm;
            send_gap = send_calm ? 0 : $urandom_range(0, 4);
         end
         if (!holding) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_requests.size() != 0) begin
               next_req = pending_requests.pop_front();
               req_ch.func      <= next_req.func;
               req_ch.operand_a <= next_req.operand_a;
               req_ch.operand_b <= next_req.operand_b;
               holding = 1'b1;
            end
         end
         req_ch.valid <= holding;
      end
   end

   // Result monitor: random stall per result, compare with the oldest expectation
   always @(posedge clock) begin : check_results
      word_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h",
                        $time, rsp_ch.result);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.result !== want) begin
                  $display("%0t: result mismatch, expected %h, actual %h",
                           $time, want, rsp_ch.result);
                  fail_count++;
               end
            end
            if ($urandom_range(0, 63) == 0) recv_calm = ~recv_calm;
            recv_stall = recv_calm ? 0 : $urandom_range(0, 4);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("int32_arith_unit_test failed");
      $finish;
   end

endmodule

>>> int32_arith_unit.f
hdl/i32au_pkg.sv
hdl/i32au_if.sv
hdl/i32au_cell.sv
hdl/i32au_chain.sv
hdl/int32_arith_unit.sv
test/int32_arith_unit_test.sv
